// ----- rtl/sm4_cbc_cipher_unit_assert.svh -----
// Assertion macros for the SM4 CBC cipher unit.
`ifndef SM4_CBC_CIPHER_UNIT_ASSERT_SVH
`define SM4_CBC_CIPHER_UNIT_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define SM4CU_ASSERT_SAME(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define SM4CU_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/sm4cbc_pkg.sv -----
// Package for the SM4 CBC cipher unit: types, constants and round functions.
`default_nettype none

package sm4cbc_pkg;

    localparam int unsigned ROUNDS_DEF  = 32;
    localparam int unsigned APB_ADDR_W  = 5;
    localparam int unsigned APB_DATA_W  = 64;
    localparam int unsigned BLOCK_W     = 128;
    localparam int unsigned USER_W      = 2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXPAND,
        ST_LOAD,
        ST_ROUND,
        ST_FINISH
    } state_t;

    typedef enum logic [1:0] {
        REG_KEY_HIGH,
        REG_KEY_LOW,
        REG_SV_HIGH,
        REG_SV_LOW
    } reg_idx_t;

    localparam logic [31:0] FK [4] = '{
        32'ha3b1bac6, 32'h56aa3350, 32'h677d9197, 32'hb27022dc
    };

    localparam logic [7:0] SBOX [256] = '{
        8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
        8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
        8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
        8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
        8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
        8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
        8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
        8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
        8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
        8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
        8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
        8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
        8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
        8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
        8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
        8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
    };

    // Byte-wise S-box on a word.
    function automatic logic [31:0] subst(input logic [31:0] a);
        return {SBOX[a[31:24]], SBOX[a[23:16]], SBOX[a[15:8]], SBOX[a[7:0]]};
    endfunction

    // Linear transform of the data rounds.
    function automatic logic [31:0] lin_round(input logic [31:0] b);
        return b ^ {b[29:0], b[31:30]} ^ {b[21:0], b[31:22]}
                 ^ {b[13:0], b[31:14]} ^ {b[7:0], b[31:8]};
    endfunction

    // Linear transform of the key schedule.
    function automatic logic [31:0] lin_key(input logic [31:0] b);
        return b ^ {b[18:0], b[31:19]} ^ {b[8:0], b[31:9]};
    endfunction

    // CK word i: byte j from the top is (4*i + j) * 7 mod 256.
    function automatic logic [31:0] ck_word(input logic [7:0] idx);
        logic [31:0] w;
        logic [7:0]  byt;
        w = '0;
        for (int j = 0; j < 4; j++)
        begin
            byt = {idx[5:0], 2'b00} + 8'(j);
            w   = {w[23:0], 8'((byt << 3) - byt)};
        end
        return w;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/sm4_cbc_cipher_unit.sv -----
// SM4 block cipher in CBC mode with APB configuration and stream ports.
//
//   channel   group                      direction  payload
//   s_*       s_tvalid/s_tready/s_tdata  in         block_high, block_low; tuser op, restart
//   m_*       m_tvalid/m_tready/m_tdata  out        result_high, result_low
//   apb       psel/penable/pwrite/paddr  in/out     key and start vector, 64-bit registers
//
// One block at a time: accept, the rounds on the shared S-box datapath, a load step to
// prefetch the first round key and a finish step to move the result into the output
// register. The first block after reset or after a key write is preceded by key
// expansion into the round key memory.
// rst_n clears control, the chain value and the registers; the round key memory is
// not cleared and is always expanded before it is read.
// A stalled output holds the result in the output register and the next block is
// taken while it waits; a block that finishes behind it waits for the slot.
`default_nettype none
`include "sm4_cbc_cipher_unit_assert.svh"

module sm4_cbc_cipher_unit #(
    parameter int unsigned ROUNDS = sm4cbc_pkg::ROUNDS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // APB configuration
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [sm4cbc_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [sm4cbc_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [sm4cbc_pkg::APB_DATA_W-1:0] prdata,
    output logic                                   pready,
    // input blocks
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [sm4cbc_pkg::BLOCK_W-1:0]    s_tdata,  // block_high, block_low
    input  wire logic [sm4cbc_pkg::USER_W-1:0]     s_tuser,  // op, restart
    // result blocks
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic      [sm4cbc_pkg::BLOCK_W-1:0]    m_tdata   // result_high, result_low
);
    import sm4cbc_pkg::*;

    localparam int unsigned RK_W = $clog2(ROUNDS);
    localparam logic [RK_W-1:0] LAST_RND = RK_W'(ROUNDS - 1);

    // configuration registers
    logic [63:0] key_hi_reg, key_lo_reg, sv_hi_reg, sv_lo_reg;
    logic        keys_ready_reg;

    // block state
    state_t      state_reg, state_next;
    logic [RK_W-1:0] cnt_reg;
    logic        op_reg;
    logic [63:0] blk_hi_reg, blk_lo_reg;
    logic [63:0] chain_hi_reg, chain_lo_reg;
    logic [31:0] w_reg [4];

    // output register
    logic         m_tvalid_reg;
    logic [127:0] m_tdata_reg;

    // round key memory
    logic [31:0]     rk_mem [ROUNDS];
    logic [31:0]     rk_rdata_reg;
    logic [RK_W-1:0] rd_cnt, rd_addr;
    logic            rk_we;

    // handshakes and control
    logic cfg_wr, s_accept, out_load, out_free;

    // datapath
    logic [63:0]  blk_hi_in, blk_lo_in, chain_hi_eff, chain_lo_eff;
    logic [31:0]  rk_sel, mix_in, sub_out, nw;
    logic [127:0] res_raw, res_out;
    logic         is_expand;

    assign pready   = 1'b1;
    assign cfg_wr   = psel & penable & pwrite & pready;
    assign s_accept = s_tvalid & s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign out_free = !m_tvalid_reg || m_tready;

    assign blk_hi_in = s_tdata[63:0];
    assign blk_lo_in = s_tdata[127:64];

    // register read back
    always_comb
    begin
        unique case (reg_idx_t'(paddr[4:3]))
            REG_KEY_HIGH: prdata = key_hi_reg;
            REG_KEY_LOW:  prdata = key_lo_reg;
            REG_SV_HIGH:  prdata = sv_hi_reg;
            REG_SV_LOW:   prdata = sv_lo_reg;
            default:      prdata = '0;
        endcase
    end

    // restart reloads the chain from the start vector
    assign chain_hi_eff = s_tuser[1] ? sv_hi_reg : chain_hi_reg;
    assign chain_lo_eff = s_tuser[1] ? sv_lo_reg : chain_lo_reg;

    // shared round: key schedule uses CK and L', data rounds the stored round key and L
    assign is_expand = (state_reg == ST_EXPAND);
    assign rk_sel    = is_expand ? ck_word(8'(cnt_reg)) : rk_rdata_reg;
    assign mix_in    = w_reg[1] ^ w_reg[2] ^ w_reg[3] ^ rk_sel;
    assign sub_out   = subst(mix_in);
    assign nw        = w_reg[0] ^ (is_expand ? lin_key(sub_out) : lin_round(sub_out));

    // final word order is reversed; decryption whitens with the chain afterwards
    assign res_raw = {w_reg[1], w_reg[0], w_reg[3], w_reg[2]};
    assign res_out = op_reg ? (res_raw ^ {chain_lo_reg, chain_hi_reg}) : res_raw;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                    state_next = keys_ready_reg ? ST_LOAD : ST_EXPAND;
            end
            ST_EXPAND:
            begin
                if (cnt_reg == LAST_RND)
                    state_next = ST_LOAD;
            end
            ST_LOAD:
                state_next = ST_ROUND;
            ST_ROUND:
            begin
                if (cnt_reg == LAST_RND)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        s_tready = (state_reg == ST_IDLE);
        rk_we    = (state_reg == ST_EXPAND);
        out_load = (state_reg == ST_FINISH) && out_free;
        // prefetch the key of the next round
        rd_cnt   = (state_reg == ST_ROUND) ? (cnt_reg + 1'b1) : '0;
        rd_addr  = op_reg ? (LAST_RND - rd_cnt) : rd_cnt;
    end

    // round key memory: written during expansion, read one round ahead
    always_ff @(posedge clk)
    begin
        if (rk_we)
            rk_mem[cnt_reg] <= nw;
        rk_rdata_reg <= rk_mem[rd_addr];
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_hi_reg     <= '0;
            key_lo_reg     <= '0;
            sv_hi_reg      <= '0;
            sv_lo_reg      <= '0;
            keys_ready_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == ST_EXPAND && cnt_reg == LAST_RND)
                keys_ready_reg <= 1'b1;
            if (cfg_wr)
            begin
                unique case (reg_idx_t'(paddr[4:3]))
                    REG_KEY_HIGH:
                    begin
                        key_hi_reg     <= pwdata;
                        keys_ready_reg <= 1'b0;
                    end
                    REG_KEY_LOW:
                    begin
                        key_lo_reg     <= pwdata;
                        keys_ready_reg <= 1'b0;
                    end
                    REG_SV_HIGH: sv_hi_reg <= pwdata;
                    REG_SV_LOW:  sv_lo_reg <= pwdata;
                    default: ;
                endcase
            end
        end
    end

    // control and chain state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            op_reg       <= 1'b0;
            chain_hi_reg <= '0;
            chain_lo_reg <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_EXPAND || state_reg == ST_ROUND)
                cnt_reg <= cnt_reg + 1'b1;
            else
                cnt_reg <= '0;
            if (s_accept)
            begin
                op_reg       <= s_tuser[0];
                chain_hi_reg <= chain_hi_eff;
                chain_lo_reg <= chain_lo_eff;
            end
            if (out_load)
            begin
                // encryption chains on its output, decryption on its input
                chain_hi_reg <= op_reg ? blk_hi_reg : res_raw[63:0];
                chain_lo_reg <= op_reg ? blk_lo_reg : res_raw[127:64];
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (out_load)
            m_tdata_reg <= res_out;
        if (s_accept)
        begin
            blk_hi_reg <= blk_hi_in;
            blk_lo_reg <= blk_lo_in;
            if (keys_ready_reg)
            begin
                // decryption feeds the block itself, encryption block xor chain
                w_reg[0] <= s_tuser[0] ? blk_hi_in[63:32] : blk_hi_in[63:32] ^ chain_hi_eff[63:32];
                w_reg[1] <= s_tuser[0] ? blk_hi_in[31:0]  : blk_hi_in[31:0]  ^ chain_hi_eff[31:0];
                w_reg[2] <= s_tuser[0] ? blk_lo_in[63:32] : blk_lo_in[63:32] ^ chain_lo_eff[63:32];
                w_reg[3] <= s_tuser[0] ? blk_lo_in[31:0]  : blk_lo_in[31:0]  ^ chain_lo_eff[31:0];
            end
            else
            begin
                w_reg[0] <= key_hi_reg[63:32] ^ FK[0];
                w_reg[1] <= key_hi_reg[31:0]  ^ FK[1];
                w_reg[2] <= key_lo_reg[63:32] ^ FK[2];
                w_reg[3] <= key_lo_reg[31:0]  ^ FK[3];
            end
        end
        else if (state_reg == ST_EXPAND && cnt_reg == LAST_RND)
        begin
            // keys done: load the cipher input from the held block
            w_reg[0] <= op_reg ? blk_hi_reg[63:32] : blk_hi_reg[63:32] ^ chain_hi_reg[63:32];
            w_reg[1] <= op_reg ? blk_hi_reg[31:0]  : blk_hi_reg[31:0]  ^ chain_hi_reg[31:0];
            w_reg[2] <= op_reg ? blk_lo_reg[63:32] : blk_lo_reg[63:32] ^ chain_lo_reg[63:32];
            w_reg[3] <= op_reg ? blk_lo_reg[31:0]  : blk_lo_reg[31:0]  ^ chain_lo_reg[31:0];
        end
        else if (state_reg == ST_EXPAND || state_reg == ST_ROUND)
        begin
            // advance the word window
            w_reg[0] <= w_reg[1];
            w_reg[1] <= w_reg[2];
            w_reg[2] <= w_reg[3];
            w_reg[3] <= nw;
        end
    end

    `SM4CU_ASSERT_SAME(a_round_needs_keys, state_reg == ST_ROUND, keys_ready_reg,
        "data round runs without expanded keys")
    `SM4CU_ASSERT_SAME(a_key_write_only_unready, rk_we, !keys_ready_reg,
        "round key memory written while keys are marked ready")
    `SM4CU_ASSERT_SAME(a_out_from_finish, $rose(m_tvalid_reg), $past(state_reg) == ST_FINISH,
        "result shown without a finished block")
    `SM4CU_ASSERT_NEXT(a_accept_no_result, s_accept, !$rose(m_tvalid_reg),
        "result appears right after an accepted block")

endmodule

`default_nettype wire

// ----- tb/sv/sm4_cbc_cipher_unit_checker.sv -----
`timescale 1ns / 1ps
// Checker for the SM4 CBC cipher unit: tracks registers, predicts result blocks, compares.

module sm4_cbc_cipher_unit_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [sm4cbc_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [sm4cbc_pkg::APB_DATA_W-1:0] pwdata,
    input  logic                              pready,
    input  logic                              s_tvalid,
    input  logic                              s_tready,
    input  logic [sm4cbc_pkg::BLOCK_W-1:0]    s_tdata,   // block_high, block_low
    input  logic [sm4cbc_pkg::USER_W-1:0]     s_tuser,   // op, restart
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic [sm4cbc_pkg::BLOCK_W-1:0]    m_tdata,   // result_high, result_low
    output int                                fail_count,
    output int                                pending
);

    import sm4cbc_pkg::*;

    localparam logic [127:0] SBOX_ROWS [16] = '{
        128'hd690e9fecce13db716b614c228fb2c05, 128'h2b679a762abe04c3aa44132649860699,
        128'h9c4250f491ef987a33540b43edcfac62, 128'he4b31ca9c908e89580df94fa758f3fa6,
        128'h4707a7fcf37317ba83593c19e6854fa8, 128'h686b81b27164da8bf8eb0f4b70569d35,
        128'h1e240e5e6358d1a225227c3b01217887, 128'hd40046579fd327524c3602e7a0c4c89e,
        128'heabf8ad240c738b5a3f7f2cef96115a1, 128'he0ae5da49b341a55ad933230f58cb1e3,
        128'h1df6e22e8266ca60c02923ab0d534e6f, 128'hd5db3745defd8e2f03ff6a726d6c5b51,
        128'h8d1baf92bbddbc7f11d95c411f105ad8, 128'h0ac13188a5cd7bbd2d74d012b8e5b4b0,
        128'h8969974a0c96777e65b9f109c56ec684, 128'h18f07dec3adc4d2079ee5f3ed7cb3948
    };

    localparam logic [31:0] KEY_SALT [4] = '{
        32'ha3b1bac6, 32'h56aa3350, 32'h677d9197, 32'hb27022dc
    };

    logic [63:0]  key_hi, key_lo, iv_hi, iv_lo;
    logic [31:0]  round_keys [32];
    logic         keys_valid;
    logic [127:0] chain;            // upper half in bits 127..64
    logic [127:0] expected_blocks [$];

    function automatic logic [31:0] rotl(input logic [31:0] w, input int n);
        return (w << n) | (w >> (32 - n));
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] a);
        logic [31:0] r;
        for (int i = 0; i < 4; i++)
            r[8*i +: 8] = SBOX_ROWS[a[8*i+4 +: 4]][8*(15 - a[8*i +: 4]) +: 8];
        return r;
    endfunction

    function automatic logic [31:0] data_mix(input logic [31:0] a);
        logic [31:0] b;
        b = sub_word(a);
        return b ^ rotl(b, 2) ^ rotl(b, 10) ^ rotl(b, 18) ^ rotl(b, 24);
    endfunction

    function automatic logic [31:0] schedule_mix(input logic [31:0] a);
        logic [31:0] b;
        b = sub_word(a);
        return b ^ rotl(b, 13) ^ rotl(b, 23);
    endfunction

    function automatic logic [31:0] ck_word(input int i);
        logic [31:0] w;
        w = '0;
        for (int j = 0; j < 4; j++)
            w = {w[23:0], 8'((4 * i + j) * 7)};
        return w;
    endfunction

    task automatic expand_round_keys();
        logic [31:0] k [4];
        logic [31:0] nk;
        k[0] = key_hi[63:32] ^ KEY_SALT[0];
        k[1] = key_hi[31:0]  ^ KEY_SALT[1];
        k[2] = key_lo[63:32] ^ KEY_SALT[2];
        k[3] = key_lo[31:0]  ^ KEY_SALT[3];
        for (int i = 0; i < 32; i++)
        begin
            nk = k[0] ^ schedule_mix(k[1] ^ k[2] ^ k[3] ^ ck_word(i));
            k[0] = k[1]; k[1] = k[2]; k[2] = k[3]; k[3] = nk;
            round_keys[i] = nk;
        end
        keys_valid = 1'b1;
    endtask

    function automatic logic [127:0] sm4_rounds(input logic [127:0] blk, input logic reverse);
        logic [31:0] x [4];
        logic [31:0] nx;
        x[0] = blk[127:96]; x[1] = blk[95:64]; x[2] = blk[63:32]; x[3] = blk[31:0];
        for (int i = 0; i < 32; i++)
        begin
            nx = x[0] ^ data_mix(x[1] ^ x[2] ^ x[3] ^ round_keys[reverse ? 31 - i : i]);
            x[0] = x[1]; x[1] = x[2]; x[2] = x[3]; x[3] = nx;
        end
        return {x[3], x[2], x[1], x[0]};
    endfunction

    task automatic predict_block(input logic decrypt, input logic restart,
                                 input logic [127:0] blk);
        logic [127:0] res;
        if (!keys_valid)
            expand_round_keys();
        if (restart)
            chain = {iv_hi, iv_lo};
        if (!decrypt)
        begin
            res   = sm4_rounds(blk ^ chain, 1'b0);
            chain = res;
        end
        else
        begin
            res   = sm4_rounds(blk, 1'b1) ^ chain;
            chain = blk;
        end
        expected_blocks.push_back(res);
    endtask

    initial
    begin
        fail_count = 0;
        pending    = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_hi     = '0;
            key_lo     = '0;
            iv_hi      = '0;
            iv_lo      = '0;
            keys_valid = 1'b0;
            chain      = '0;
            expected_blocks.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (reg_idx_t'(paddr[4:3]))
                    REG_KEY_HIGH: begin key_hi = pwdata; keys_valid = 1'b0; end
                    REG_KEY_LOW:  begin key_lo = pwdata; keys_valid = 1'b0; end
                    REG_SV_HIGH:  iv_hi = pwdata;
                    REG_SV_LOW:   iv_lo = pwdata;
                endcase
            end
            if (s_tvalid && s_tready)
                predict_block(s_tuser[0], s_tuser[1], {s_tdata[63:0], s_tdata[127:64]});
            if (m_tvalid && m_tready)
            begin
                if (expected_blocks.size() == 0)
                begin
                    $error("result_high/result_low: unexpected result %h %h",
                           m_tdata[63:0], m_tdata[127:64]);
                    fail_count++;
                end
                else
                begin
                    logic [127:0] want;
                    want = expected_blocks.pop_front();
                    if (m_tdata[63:0] !== want[127:64])
                    begin
                        $error("result_high: expected %h, got %h", want[127:64], m_tdata[63:0]);
                        fail_count++;
                    end
                    if (m_tdata[127:64] !== want[63:0])
                    begin
                        $error("result_low: expected %h, got %h", want[63:0], m_tdata[127:64]);
                        fail_count++;
                    end
                end
            end
        end
        pending = expected_blocks.size();
    end

endmodule

// ----- tb/sv/sm4_cbc_cipher_unit_tb.sv -----
`timescale 1ns / 1ps
// Top of the SM4 CBC cipher unit testbench: clock, reset, stimulus and verdict.

module sm4_cbc_cipher_unit_tb;

    import sm4cbc_pkg::*;

    // op codes carried in s_tuser[0]; restart rides in s_tuser[1]
    localparam logic OP_ENCRYPT = 1'b0;
    localparam logic OP_DECRYPT = 1'b1;

    // percent of cycles in which a side idles
    localparam int IDLE_PCT = 21;

    logic                  clk;
    logic                  rst_n;
    logic                  psel, penable, pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  s_tvalid, s_tready;
    logic [BLOCK_W-1:0]    s_tdata;   // block_high, block_low
    logic [USER_W-1:0]     s_tuser;   // op, restart
    logic                  m_tvalid, m_tready;
    logic [BLOCK_W-1:0]    m_tdata;   // result_high, result_low

    int fail_count;
    int pending;
    bit steady;      // suppress idling on both sides while set

    sm4_cbc_cipher_unit u_dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    sm4_cbc_cipher_unit_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .fail_count(fail_count), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Roll the idle dice for one cycle.
    function automatic bit take_break();
        return !steady && ($urandom_range(99) < IDLE_PCT);
    endfunction

    // Pick a 64-bit half, biased toward the extremes.
    function automatic logic [63:0] pick_half();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Write one 64-bit register: setup cycle, then access until pready.
    task automatic reg_write(input reg_idx_t idx, input logic [63:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Offer one block and hold it until the transfer completes.
    task automatic send_block(input logic op, input logic restart,
                              input logic [63:0] hi, input logic [63:0] lo);
        @(negedge clk);
        while (take_break())
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {lo, hi};
        s_tuser  <= {restart, op};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // Drop valid and hold until every predicted result has been taken.
    task automatic drain();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    // Receiver side: stall at random on the falling edge.
    always @(negedge clk)
        m_tready <= !take_break();

    // Run limit: ~450 blocks, even with key expansion and both sides
    // stalling, fit far inside this bound.
    initial
    begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        int          sent;
        int          run_len;
        logic        run_op;
        logic        first_restart;
        logic        op, restart;

        rst_n    = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        m_tready = 1'b0;
        steady   = 1'b0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        // --- directed part ---
        // Straight out of reset: zero key, chain starts from zero without restart.
        send_block(OP_ENCRYPT, 1'b0, 64'h0, 64'h0);
        send_block(OP_DECRYPT, 1'b0, '1, '1);
        send_block(OP_ENCRYPT, 1'b1, '1, 64'h0);
        drain();

        // Standard key and vector; zero IV makes the first block plain ECB.
        reg_write(REG_KEY_HIGH, 64'h0123456789abcdef);
        reg_write(REG_KEY_LOW,  64'hfedcba9876543210);
        reg_write(REG_SV_HIGH,  64'h0);
        reg_write(REG_SV_LOW,   64'h0);
        send_block(OP_ENCRYPT, 1'b1, 64'h0123456789abcdef, 64'hfedcba9876543210);
        send_block(OP_DECRYPT, 1'b1, 64'h681edf34d206965e, 64'h86b3e94f536e4246);
        send_block(OP_ENCRYPT, 1'b0, 64'h0, '1);
        send_block(OP_DECRYPT, 1'b0, '1, 64'h0);
        drain();

        // New start vector alone: chain keeps going until a restart.
        reg_write(REG_SV_HIGH, '1);
        reg_write(REG_SV_LOW,  '1);
        send_block(OP_ENCRYPT, 1'b0, 64'h0, 64'h0);
        send_block(OP_ENCRYPT, 1'b1, 64'h0, 64'h0);
        send_block(OP_DECRYPT, 1'b1, 64'h8000000000000001, 64'h8000000000000001);
        drain();

        // One key half changed: expansion must rerun.
        reg_write(REG_KEY_HIGH, '1);
        send_block(OP_ENCRYPT, 1'b0, '1, '1);
        send_block(OP_DECRYPT, 1'b0, 64'h0, 64'h0);
        drain();
        reg_write(REG_KEY_LOW, '1);
        send_block(OP_DECRYPT, 1'b1, '1, '1);
        send_block(OP_ENCRYPT, 1'b0, 64'h5555555555555555, 64'haaaaaaaaaaaaaaaa);
        drain();

        reg_write(REG_KEY_HIGH, 64'h0);
        reg_write(REG_KEY_LOW,  64'h0);
        reg_write(REG_SV_HIGH,  64'h0);
        reg_write(REG_SV_LOW,   64'h0);
        send_block(OP_ENCRYPT, 1'b1, 64'h0, 64'h0);
        send_block(OP_DECRYPT, 1'b0, '1, '1);

        // --- random part: eight phases of about fifty blocks ---
        for (int phase = 0; phase < 8; phase++)
        begin
            drain();
            steady = (phase == 3);
            if (phase == 0 || $urandom_range(7) < 5)
            begin
                reg_write(REG_KEY_HIGH, (phase == 1) ? '1 : (phase == 2) ? '0 : pick_half());
                reg_write(REG_KEY_LOW,  (phase == 1) ? '1 : (phase == 2) ? '0 : pick_half());
            end
            else if ($urandom_range(1))
                reg_write(REG_KEY_LOW, pick_half());
            reg_write(REG_SV_HIGH, pick_half());
            reg_write(REG_SV_LOW,  pick_half());

            sent = 0;
            while (sent < 50)
            begin
                // Mostly chains: restart, then a run of one direction.
                run_len       = $urandom_range(1, 8);
                run_op        = 1'($urandom_range(1));
                first_restart = ($urandom_range(9) != 0);
                for (int i = 0; i < run_len; i++)
                begin
                    op      = ($urandom_range(9) == 0) ? ~run_op : run_op;
                    restart = (i == 0) ? first_restart : ($urandom_range(15) == 0);
                    send_block(op, restart, pick_half(), pick_half());
                    sent++;
                end
                // Hold the sender once until the unit has emptied out.
                if (phase == 5 && sent >= 20 && sent < 20 + run_len)
                    drain();
            end
        end
        steady = 1'b0;

        drain();
        repeat (100) @(negedge clk);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
